// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue: store depth, index
// and count widths, command and status codes, item and result layouts.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = 5;
	localparam int WORD_W = 32;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_CLEAR      = 3'd4
	} deq_cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} deq_status_t;

	typedef struct packed {
		logic [2:0]               command;
		logic signed [WORD_W-1:0] value;
	} deq_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] popped_value;
		logic [1:0]               status;
		logic                     is_empty;
		logic [CNT_W-1:0]         entry_count;
	} deq_result_t;

endpackage

// ===== rtl/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read synchronous RAM with registered read
// data.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int DEPTH_P = 16,
	parameter int WIDTH_P = 32,
	parameter int ADDR_W  = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  logic [WIDTH_P-1:0] wr_data,
	input  logic               rd_en,
	input  logic [ADDR_W-1:0]  rd_addr,
	output logic [WIDTH_P-1:0] rd_data
);

	logic [WIDTH_P-1:0] mem [DEPTH_P];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of signed 32-bit words in a circular store of DEPTH
// slots: push and pop at either end, clear, one result per command.
// ----------------------------------------------------------------------------
// Usage: the block takes one command item per clock (busy stays low) and
// delivers its result in the next cycle, marked by done for one cycle.
// The receiver cannot stall, so capture result whenever done is high. The
// result comes from the registered read port of the slot RAM: head, tail
// and count are updated at the accepting edge, and the RAM read for a pop
// is registered at that same edge, so the word is out along with done.
// A push onto a full store is dropped with status full; a pop on an empty
// store returns zero with status empty. Clear resets the pointers and the
// count in one step and leaves the slot contents in place, unreachable.
// Slots need no clearing after reset: a pop only reads slots that a push
// has written.
// ----------------------------------------------------------------------------
module double_ended_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  deq_pkg::deq_item_t   item,
	output logic                 done,
	output deq_pkg::deq_result_t result
);

	import deq_pkg::*;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	// Pointer and count state.
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;

	// Result stage, lined up with the RAM read data.
	logic             done_s1;
	logic             pop_ok_s1;
	deq_status_t      status_s1;
	logic [CNT_W-1:0] count_s1;

	// Next-state and RAM controls.
	logic             accept;
	logic [IDX_W-1:0] head_d;
	logic [IDX_W-1:0] tail_d;
	logic [CNT_W-1:0] count_d;
	deq_status_t      status_d;
	logic             pop_ok_d;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [WORD_W-1:0] rd_data;
	logic             is_full;
	logic             is_zero;
	logic [IDX_W-1:0] head_inc;
	logic [IDX_W-1:0] head_dec;
	logic [IDX_W-1:0] tail_inc;
	logic [IDX_W-1:0] tail_dec;

	// Never stall: every command completes in the cycle after it is taken.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign is_full  = (count_q == CNT_FULL);
	assign is_zero  = (count_q == '0);
	assign head_inc = (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? IDX_LAST : head_q - 1'b1;
	assign tail_inc = (tail_q == IDX_LAST) ? '0 : tail_q + 1'b1;
	assign tail_dec = (tail_q == '0) ? IDX_LAST : tail_q - 1'b1;

	// Decode the command: pick the slot to touch and the new pointers.
	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		status_d = ST_OK;
		pop_ok_d = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = tail_q;
		rd_en    = 1'b0;
		rd_addr  = head_q;
		case (item.command)
			CMD_PUSH_FRONT: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					// Step the head back, then write the new front word there.
					head_d  = head_dec;
					wr_en   = accept;
					wr_addr = head_dec;
					count_d = count_q + 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					wr_en   = accept;
					wr_addr = tail_q;
					tail_d  = tail_inc;
					count_d = count_q + 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (is_zero) begin
					status_d = ST_EMPTY;
				end else begin
					rd_en    = accept;
					rd_addr  = head_q;
					head_d   = head_inc;
					count_d  = count_q - 1'b1;
					pop_ok_d = 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (is_zero) begin
					status_d = ST_EMPTY;
				end else begin
					// The back word sits one slot before the tail.
					tail_d   = tail_dec;
					rd_en    = accept;
					rd_addr  = tail_dec;
					count_d  = count_q - 1'b1;
					pop_ok_d = 1'b1;
				end
			end
			CMD_CLEAR: begin
				head_d  = '0;
				tail_d  = '0;
				count_d = '0;
			end
			default: begin
				// Unused codes: no operation, status ok.
			end
		endcase
	end

	deq_ram #(
		.DEPTH_P (DEPTH),
		.WIDTH_P (WORD_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (item.value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Advance pointers at the accepting edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	// Register the result fields beside the RAM read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1   <= 1'b0;
			pop_ok_s1 <= 1'b0;
		end else begin
			done_s1   <= accept;
			pop_ok_s1 <= accept && pop_ok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			count_s1  <= count_d;
		end
	end

	assign done                = done_s1;
	assign result.popped_value = pop_ok_s1 ? $signed(rd_data) : '0;
	assign result.status       = status_s1;
	assign result.is_empty     = (count_s1 == '0);
	assign result.entry_count  = count_s1;

	// Distance from head to tail around the ring, for the pointer check.
	logic [IDX_W:0] ptr_gap;
	logic [IDX_W:0] cnt_mod;

	assign ptr_gap = (tail_q >= head_q) ? {1'b0, tail_q} - {1'b0, head_q}
	                                    : {1'b0, tail_q} + (IDX_W+1)'(DEPTH) - {1'b0, head_q};
	assign cnt_mod = (count_q == CNT_FULL) ? '0 : (IDX_W+1)'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("entry count above depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_gap == cnt_mod)
		else $error("head, tail and count disagree");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted item gave no result");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_FULL) |-> (result.entry_count == CNT_FULL))
		else $error("full status without a full store");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |-> (result.popped_value == '0))
		else $error("failed command returned a word");

endmodule

// ===== test/deq_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deq_result_checker
// Watches the command and result channels of the double-ended queue, keeps a
// mirror of the store, and compares every result against the mirror's answer.
// ----------------------------------------------------------------------------
module deq_result_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  deq_pkg::deq_item_t   item,
	input  logic                 done,
	input  deq_pkg::deq_result_t result,
	output int                   mismatches,
	output int                   pending
);
	import deq_pkg::*;

	localparam int REPORT_LIMIT = 10;

	logic signed [WORD_W-1:0] mirror_slots [DEPTH];
	logic [IDX_W-1:0]         front_idx;
	logic [IDX_W-1:0]         back_idx;
	int unsigned              held;
	deq_result_t              awaited_results [$];
	deq_result_t              oldest;

	function automatic logic [IDX_W-1:0] idx_next(logic [IDX_W-1:0] idx);
		return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_prev(logic [IDX_W-1:0] idx);
		return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - 1'b1;
	endfunction

	// Apply one command to the mirror and return the result it must produce.
	function automatic deq_result_t apply_to_mirror(deq_item_t cmd_item);
		deq_result_t r;
		r = '0;
		r.status = ST_OK;
		case (cmd_item.command)
			CMD_PUSH_FRONT: begin
				if (held >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					front_idx = idx_prev(front_idx);
					mirror_slots[front_idx] = cmd_item.value;
					held++;
				end
			end
			CMD_PUSH_BACK: begin
				if (held >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					mirror_slots[back_idx] = cmd_item.value;
					back_idx = idx_next(back_idx);
					held++;
				end
			end
			CMD_POP_FRONT: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.popped_value = mirror_slots[front_idx];
					front_idx = idx_next(front_idx);
					held--;
				end
			end
			CMD_POP_BACK: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					back_idx = idx_prev(back_idx);
					r.popped_value = mirror_slots[back_idx];
					held--;
				end
			end
			CMD_CLEAR: begin
				front_idx = '0;
				back_idx  = '0;
				held      = 0;
			end
			default: begin
				// unused codes leave everything as it is
			end
		endcase
		r.is_empty    = (held == 0);
		r.entry_count = CNT_W'(held);
		return r;
	endfunction

	// Queue the expectation first, so a result that lands on the accepting
	// edge still finds its entry; then retire the oldest on every strobe.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_idx  = '0;
			back_idx   = '0;
			held       = 0;
			mismatches = 0;
			awaited_results.delete();
			pending <= 0;
		end else begin
			if (start && !busy)
				awaited_results.insert(awaited_results.size(), apply_to_mirror(item));
			if (done) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: unexpected result: value %0d status %0d count %0d",
							$time, result.popped_value, result.status,
							result.entry_count);
				end else begin
					oldest = awaited_results[0];
					awaited_results.delete(0);
					if (result.popped_value !== oldest.popped_value
							|| result.status !== oldest.status
							|| result.is_empty !== oldest.is_empty
							|| result.entry_count !== oldest.entry_count) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("%0t: expected %0d status %0d empty %0b count %0d",
								$time, oldest.popped_value, oldest.status,
								oldest.is_empty, oldest.entry_count);
							$display("%0t: actual   %0d status %0d empty %0b count %0d",
								$time, result.popped_value, result.status,
								result.is_empty, result.entry_count);
						end
					end
				end
			end
			pending <= awaited_results.size();
		end
	end

endmodule

// ===== test/double_ended_queue_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Drives push, pop and clear commands into the double-ended queue: a directed
// opening over empty pops, word extremes and unused codes, then random phases
// that fill, drain or mix, so the store wraps and hits full and empty often.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
	import deq_pkg::*;

	localparam int ITEM_TARGET   = 600;
	localparam int CALM_TAIL     = 500;   // no idling once this many items went in
	localparam int QUIET_LIMIT   = 2000;  // cycles with no traffic before giving up
	localparam int DRAIN_CYCLES  = 4;
	localparam int CMD_CODE_MAX  = 7;
	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	deq_item_t   item;
	logic        done;
	deq_result_t result;
	int          mismatches;
	int          pending;
	int          quiet_cycles;

	double_ended_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	deq_result_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.done       (done),
		.result     (result),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Present one item and hold it until the block takes it.
	task automatic send_item(input logic [2:0] code, input logic signed [WORD_W-1:0] word);
		start <= 1'b1;
		item  <= '{command: code, value: word};
		do @(posedge clk); while (busy);
	endtask

	// Drop start for a short burst.
	task automatic idle_burst(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Bias toward the word extremes so the sign bit and all-ones show up often.
	function automatic logic signed [WORD_W-1:0] random_word();
		case ($urandom_range(0, 7))
			0:       return WORD_MIN;
			1:       return WORD_MAX;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Count cycles with nothing accepted and nothing delivered.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int          sent;
		int          phase_len;
		int          push_pct;
		int          pick;
		bit          idle_on;
		logic [2:0]  code;

		arst_n       = 1'b0;
		start        = 1'b0;
		item         = '0;
		quiet_cycles = 0;
		sent         = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening: pops on an empty queue, extremes at both ends,
		// unused codes, then clear and a pop after it.
		send_item(CMD_POP_FRONT, '0);
		send_item(CMD_POP_BACK, '0);
		send_item(CMD_PUSH_FRONT, WORD_MIN);
		send_item(CMD_PUSH_BACK, WORD_MAX);
		send_item(CMD_PUSH_FRONT, '0);
		send_item(CMD_PUSH_BACK, '1);
		send_item(CMD_POP_FRONT, '0);
		send_item(CMD_POP_BACK, '0);
		for (int c = CMD_CLEAR + 1; c <= CMD_CODE_MAX; c++)
			send_item(3'(c), '1);
		send_item(CMD_POP_BACK, '0);
		send_item(CMD_POP_FRONT, '0);
		send_item(CMD_PUSH_BACK, 32'sh5a5a_a5a5);
		send_item(CMD_PUSH_FRONT, 32'sh a5a5_5a5a);
		send_item(CMD_CLEAR, '0);
		send_item(CMD_POP_FRONT, '0);
		send_item(CMD_PUSH_FRONT, -32'sd2);
		send_item(CMD_POP_BACK, '0);

		// Random phases: fill-leaning runs reach full and wrap the indices,
		// drain-leaning runs hit empty, mixed runs stir both ends.
		while (sent < ITEM_TARGET) begin
			case ($urandom_range(0, 2))
				0:       push_pct = 80;
				1:       push_pct = 20;
				default: push_pct = 50;
			endcase
			phase_len = $urandom_range(8, 40);
			idle_on   = (sent < CALM_TAIL) && ($urandom_range(0, 2) != 0);
			repeat (phase_len) begin
				pick = $urandom_range(0, 99);
				if (pick < 2)
					code = CMD_CLEAR;
				else if (pick < 5)
					code = 3'($urandom_range(CMD_CLEAR + 1, CMD_CODE_MAX));
				else if ($urandom_range(0, 99) < push_pct)
					code = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
				else
					code = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
				if (idle_on && sent < CALM_TAIL && $urandom_range(0, 3) == 0)
					idle_burst($urandom_range(1, 5));
				send_item(code, random_word());
				if (code <= CMD_CLEAR)
					sent++;
			end
		end
		start <= 1'b0;

		// Wait for the last results, then let the pipeline settle.
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/double_ended_queue.sv
test/deq_result_checker.sv
test/double_ended_queue_tb.sv
